>>> hdl/weighted_reading_merge_macros.svh
// Assertion helpers for the weighted reading merge block.
`ifndef WEIGHTED_READING_MERGE_MACROS_SVH
`define WEIGHTED_READING_MERGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WRM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wrm_pkg.sv
package wrm_pkg;

   localparam int unsigned STATUS_W = 4;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned WPORT_W  = 16;
   localparam int unsigned LAT_W    = 31;
   localparam int unsigned LON_W    = 32;
   localparam int unsigned ALT_W    = 21;
   localparam int unsigned TIME_W   = 64;

   // status bit positions
   localparam int unsigned ST_PARSED = 0;
   localparam int unsigned ST_VALID  = 1;
   localparam int unsigned ST_SENSOR = 2;
   localparam int unsigned ST_GPS    = 3;

   localparam logic FUNC_MERGE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_DIV,
      S_EMIT
   } wrm_state_type;

endpackage

>>> hdl/weighted_reading_merge.sv
// Weighted reading merge. Every accepted transaction on req_ yields exactly one transaction
// on rsp_ carrying the accumulator after that item. Clear, ignored and copy-in items go
// from the accept straight to loading the output register. A true merge runs both count-rate
// averages on one shared 16-by-WEIGHT_WIDTH multiplier and one restoring divider: per rate
// the multiply states S_MUL_A and S_MUL_B, then the divide, one quotient bit per cycle.
// req_ready is low while an item is in work; a finished result sits in the rsp_ output
// register while the next item is accepted.
`include "weighted_reading_merge_macros.svh"

module weighted_reading_merge #(
   parameter int unsigned WEIGHT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic        [wrm_pkg::STATUS_W-1:0] req_in_status,
   input  logic        [wrm_pkg::WPORT_W-1:0]  req_in_weight,
   input  logic        [wrm_pkg::RATE_W-1:0]   req_in_rate_minute,
   input  logic        [wrm_pkg::RATE_W-1:0]   req_in_rate_block,
   input  logic        [wrm_pkg::COUNT_W-1:0]  req_in_total,
   input  logic signed [wrm_pkg::LAT_W-1:0]    req_in_lat,
   input  logic signed [wrm_pkg::LON_W-1:0]    req_in_lon,
   input  logic signed [wrm_pkg::ALT_W-1:0]    req_in_alt,
   input  logic        [wrm_pkg::TIME_W-1:0]   req_in_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [wrm_pkg::STATUS_W-1:0] rsp_out_status,
   output logic        [wrm_pkg::WPORT_W-1:0]  rsp_out_weight,
   output logic        [wrm_pkg::RATE_W-1:0]   rsp_out_rate_minute,
   output logic        [wrm_pkg::RATE_W-1:0]   rsp_out_rate_block,
   output logic        [wrm_pkg::COUNT_W-1:0]  rsp_out_total,
   output logic signed [wrm_pkg::LAT_W-1:0]    rsp_out_lat,
   output logic signed [wrm_pkg::LON_W-1:0]    rsp_out_lon,
   output logic signed [wrm_pkg::ALT_W-1:0]    rsp_out_alt,
   output logic        [wrm_pkg::TIME_W-1:0]   rsp_out_time,
   output logic                                rsp_reportable
);

   import wrm_pkg::*;

   localparam int unsigned WW = WEIGHT_WIDTH;
   localparam int unsigned EW = (WW > WPORT_W) ? WW : WPORT_W;
   localparam int unsigned DW = WW + 1;           // divisor and remainder
   localparam int unsigned PW = RATE_W + WW;      // product
   localparam int unsigned NW = RATE_W + WW + 1;  // numerator
   localparam int unsigned CW = $clog2(RATE_W);

   localparam logic [WW-1:0] WMAX = {WW{1'b1}};

   wrm_state_type state_ff, state_in;

   // accumulator
   logic        [STATUS_W-1:0] acc_status_ff, acc_status_in;
   logic        [WW-1:0]       acc_weight_ff, acc_weight_in;
   logic        [RATE_W-1:0]   acc_rate_ff [2];
   logic        [RATE_W-1:0]   acc_rate_in [2];
   logic        [COUNT_W-1:0]  acc_total_ff, acc_total_in;
   logic signed [LAT_W-1:0]    acc_lat_ff, acc_lat_in;
   logic signed [LON_W-1:0]    acc_lon_ff, acc_lon_in;
   logic signed [ALT_W-1:0]    acc_alt_ff, acc_alt_in;
   logic        [TIME_W-1:0]   acc_time_ff, acc_time_in;

   // arithmetic work registers; index 0 is the minute rate, 1 the block rate
   logic [RATE_W-1:0] opa_ff [2];
   logic [RATE_W-1:0] opa_in [2];
   logic [RATE_W-1:0] opb_ff [2];
   logic [RATE_W-1:0] opb_in [2];
   logic [WW-1:0]     w_ff, w_in;
   logic [DW-1:0]     den_ff, den_in;
   logic              sel_ff, sel_in;
   logic [NW-1:0]     num_ff, num_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [RATE_W-1:0] low_ff, low_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic        [STATUS_W-1:0] out_status_ff;
   logic        [WPORT_W-1:0]  out_weight_ff;
   logic        [RATE_W-1:0]   out_rate_minute_ff;
   logic        [RATE_W-1:0]   out_rate_block_ff;
   logic        [COUNT_W-1:0]  out_total_ff;
   logic signed [LAT_W-1:0]    out_lat_ff;
   logic signed [LON_W-1:0]    out_lon_ff;
   logic signed [ALT_W-1:0]    out_alt_ff;
   logic        [TIME_W-1:0]   out_time_ff;
   logic                       out_reportable_ff;

   logic              accept;
   logic              slot_free;
   logic              load_out;
   logic [EW-1:0]     w_raw_ext;
   logic [WW-1:0]     w_clamp;
   logic [EW-1:0]     acc_w_ext;
   logic              do_merge;
   logic              acc_sens;
   logic              item_sens;
   logic [RATE_W-1:0] mul_x;
   logic [WW-1:0]     mul_y;
   logic [PW-1:0]     product;
   logic [NW-1:0]     num_sum;
   logic [DW:0]       trial;
   logic [DW:0]       diff;
   logic              q_bit;
   logic [RATE_W-1:0] quotient;
   logic [WW-1:0]     w_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load_out  = (state_ff == S_EMIT) && slot_free;

   assign w_raw_ext = EW'(req_in_weight);
   assign w_clamp   = (w_raw_ext > EW'(WMAX)) ? WMAX : w_raw_ext[WW-1:0];
   assign acc_w_ext = EW'(acc_weight_ff);
   assign acc_sens  = acc_status_ff[ST_SENSOR];
   assign item_sens = req_in_status[ST_SENSOR];
   assign do_merge  = (req_func == FUNC_MERGE) && req_in_status[ST_VALID]
                      && (req_in_weight != '0);

   // shared multiplier: acc rate times acc weight, then item rate times item weight
   assign mul_x   = (state_ff == S_MUL_A) ? opa_ff[sel_ff] : opb_ff[sel_ff];
   assign mul_y   = (state_ff == S_MUL_A) ? acc_weight_ff : w_ff;
   assign product = PW'(mul_x) * PW'(mul_y);
   assign num_sum = num_ff + NW'(product);

   // restoring divider, one quotient bit per cycle
   assign trial    = {rem_ff, low_ff[RATE_W-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign q_bit    = (trial >= {1'b0, den_ff});
   assign quotient = {low_ff[RATE_W-2:0], q_bit};

   // den_ff holds the unsaturated weight sum
   assign w_sat = den_ff[WW] ? WMAX : den_ff[WW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (do_merge && (acc_weight_ff != '0)) begin
                  state_in = S_MUL_A;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: state_in = S_DIV;
         S_DIV: begin
            if (cnt_ff == CW'(RATE_W - 1)) begin
               state_in = sel_ff ? S_EMIT : S_MUL_A;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      acc_status_in  = acc_status_ff;
      acc_weight_in  = acc_weight_ff;
      acc_rate_in    = acc_rate_ff;
      acc_total_in   = acc_total_ff;
      acc_lat_in     = acc_lat_ff;
      acc_lon_in     = acc_lon_ff;
      acc_alt_in     = acc_alt_ff;
      acc_time_in    = acc_time_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      w_in           = w_ff;
      den_in         = den_ff;
      sel_in         = sel_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      cnt_in         = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_CLEAR) begin
                  acc_weight_in = '0;
                  acc_status_in = '0;
               end else if (do_merge && (acc_weight_ff == '0)) begin
                  acc_status_in  = req_in_status;
                  acc_weight_in  = w_clamp;
                  acc_rate_in[0] = req_in_rate_minute;
                  acc_rate_in[1] = req_in_rate_block;
                  acc_total_in   = req_in_total;
                  acc_lat_in     = req_in_lat;
                  acc_lon_in     = req_in_lon;
                  acc_alt_in     = req_in_alt;
                  acc_time_in    = req_in_time;
               end else if (do_merge) begin
                  acc_time_in  = req_in_time;
                  acc_total_in = req_in_total;
                  acc_status_in[ST_PARSED] = acc_status_ff[ST_PARSED]
                                             | req_in_status[ST_PARSED];
                  acc_status_in[ST_SENSOR] = acc_sens | item_sens;
                  if (req_in_status[ST_GPS]) begin
                     acc_status_in[ST_GPS] = 1'b1;
                     acc_lat_in = req_in_lat;
                     acc_lon_in = req_in_lon;
                     acc_alt_in = req_in_alt;
                  end
                  // a side without sensor ok borrows the other side's rates
                  opa_in[0] = (item_sens && !acc_sens) ? req_in_rate_minute : acc_rate_ff[0];
                  opa_in[1] = (item_sens && !acc_sens) ? req_in_rate_block : acc_rate_ff[1];
                  opb_in[0] = (acc_sens && !item_sens) ? acc_rate_ff[0] : req_in_rate_minute;
                  opb_in[1] = (acc_sens && !item_sens) ? acc_rate_ff[1] : req_in_rate_block;
                  w_in   = w_clamp;
                  den_in = {1'b0, acc_weight_ff} + {1'b0, w_clamp};
                  sel_in = 1'b0;
               end
            end
         end
         S_MUL_A: begin
            num_in = NW'(product);
         end
         S_MUL_B: begin
            // quotient fits in RATE_W bits, so the high part starts below the divisor
            rem_in = num_sum[NW-1:RATE_W];
            low_in = num_sum[RATE_W-1:0];
            cnt_in = '0;
         end
         S_DIV: begin
            rem_in = q_bit ? diff[DW-1:0] : trial[DW-1:0];
            low_in = quotient;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(RATE_W - 1)) begin
               acc_rate_in[sel_ff] = quotient;
               sel_in = 1'b1;
               if (sel_ff) begin
                  acc_weight_in = w_sat;
               end
            end
         end
         S_EMIT: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         acc_status_ff <= '0;
         acc_weight_ff <= '0;
         acc_rate_ff   <= '{default: '0};
         acc_total_ff  <= '0;
         acc_lat_ff    <= '0;
         acc_lon_ff    <= '0;
         acc_alt_ff    <= '0;
         acc_time_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_status_ff <= acc_status_in;
         acc_weight_ff <= acc_weight_in;
         acc_rate_ff   <= acc_rate_in;
         acc_total_ff  <= acc_total_in;
         acc_lat_ff    <= acc_lat_in;
         acc_lon_ff    <= acc_lon_in;
         acc_alt_ff    <= acc_alt_in;
         acc_time_ff   <= acc_time_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      w_ff   <= w_in;
      den_ff <= den_in;
      sel_ff <= sel_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
      if (load_out) begin
         out_status_ff      <= acc_status_ff;
         out_weight_ff      <= acc_w_ext[WPORT_W-1:0];
         out_rate_minute_ff <= acc_rate_ff[0];
         out_rate_block_ff  <= acc_rate_ff[1];
         out_total_ff       <= acc_total_ff;
         out_lat_ff         <= acc_lat_ff;
         out_lon_ff         <= acc_lon_ff;
         out_alt_ff         <= acc_alt_ff;
         out_time_ff        <= acc_time_ff;
         out_reportable_ff  <= (acc_weight_ff != '0) && acc_status_ff[ST_SENSOR]
                               && acc_status_ff[ST_GPS];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_status      = out_status_ff;
   assign rsp_out_weight      = out_weight_ff;
   assign rsp_out_rate_minute = out_rate_minute_ff;
   assign rsp_out_rate_block  = out_rate_block_ff;
   assign rsp_out_total       = out_total_ff;
   assign rsp_out_lat         = out_lat_ff;
   assign rsp_out_lon         = out_lon_ff;
   assign rsp_out_alt         = out_alt_ff;
   assign rsp_out_time        = out_time_ff;
   assign rsp_reportable      = out_reportable_ff;

   `WRM_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != S_IDLE, "accepted item did not start")
   `WRM_ASSERT_NOW(a_rem_below_den, state_ff == S_DIV, rem_ff < den_ff, "divider remainder overflow")
   `WRM_ASSERT_NEXT(a_weight_held_in_mul, (state_ff == S_MUL_A) || (state_ff == S_MUL_B), $stable(acc_weight_ff), "weight changed during multiply")
   `WRM_ASSERT_NOW(a_report_needs_flags, rsp_valid && rsp_reportable, rsp_out_status[ST_SENSOR] && rsp_out_status[ST_GPS], "reportable without sensor and gps")

endmodule

>>> verif/tb_weighted_reading_merge.sv
module tb_weighted_reading_merge;
   timeunit 1ns;
   timeprecision 1ps;

   import wrm_pkg::*;

   localparam logic [STATUS_W-1:0] SB_PARSED = STATUS_W'(1 << ST_PARSED);
   localparam logic [STATUS_W-1:0] SB_VALID  = STATUS_W'(1 << ST_VALID);
   localparam logic [STATUS_W-1:0] SB_SENSOR = STATUS_W'(1 << ST_SENSOR);
   localparam logic [STATUS_W-1:0] SB_GPS    = STATUS_W'(1 << ST_GPS);
   localparam logic [WPORT_W-1:0]  WEIGHT_MAX = '1;
   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned PRESSURE_AT  = 300;
   localparam int unsigned PRESSURE_LEN = 400;

   typedef struct packed {
      logic                       func;
      logic        [STATUS_W-1:0] status;
      logic        [WPORT_W-1:0]  weight;
      logic        [RATE_W-1:0]   rate_minute;
      logic        [RATE_W-1:0]   rate_block;
      logic        [COUNT_W-1:0]  total;
      logic signed [LAT_W-1:0]    lat;
      logic signed [LON_W-1:0]    lon;
      logic signed [ALT_W-1:0]    alt;
      logic        [TIME_W-1:0]   stamp;
   } reading_item_type;

   typedef struct packed {
      logic        [STATUS_W-1:0] status;
      logic        [WPORT_W-1:0]  weight;
      logic        [RATE_W-1:0]   rate_minute;
      logic        [RATE_W-1:0]   rate_block;
      logic        [COUNT_W-1:0]  total;
      logic signed [LAT_W-1:0]    lat;
      logic signed [LON_W-1:0]    lon;
      logic signed [ALT_W-1:0]    alt;
      logic        [TIME_W-1:0]   stamp;
      logic                       reportable;
   } merged_reading_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_func = FUNC_MERGE;
   logic        [STATUS_W-1:0] req_in_status = '0;
   logic        [WPORT_W-1:0]  req_in_weight = '0;
   logic        [RATE_W-1:0]   req_in_rate_minute = '0;
   logic        [RATE_W-1:0]   req_in_rate_block = '0;
   logic        [COUNT_W-1:0]  req_in_total = '0;
   logic signed [LAT_W-1:0]    req_in_lat = '0;
   logic signed [LON_W-1:0]    req_in_lon = '0;
   logic signed [ALT_W-1:0]    req_in_alt = '0;
   logic        [TIME_W-1:0]   req_in_time = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic        [STATUS_W-1:0] rsp_out_status;
   logic        [WPORT_W-1:0]  rsp_out_weight;
   logic        [RATE_W-1:0]   rsp_out_rate_minute;
   logic        [RATE_W-1:0]   rsp_out_rate_block;
   logic        [COUNT_W-1:0]  rsp_out_total;
   logic signed [LAT_W-1:0]    rsp_out_lat;
   logic signed [LON_W-1:0]    rsp_out_lon;
   logic signed [ALT_W-1:0]    rsp_out_alt;
   logic        [TIME_W-1:0]   rsp_out_time;
   logic                       rsp_reportable;

   // accumulated reading as the block should hold it
   logic        [STATUS_W-1:0] held_status = '0;
   logic        [WPORT_W-1:0]  held_weight = '0;
   logic        [RATE_W-1:0]   held_rate_minute = '0;
   logic        [RATE_W-1:0]   held_rate_block = '0;
   logic        [COUNT_W-1:0]  held_total = '0;
   logic signed [LAT_W-1:0]    held_lat = '0;
   logic signed [LON_W-1:0]    held_lon = '0;
   logic signed [ALT_W-1:0]    held_alt = '0;
   logic        [TIME_W-1:0]   held_stamp = '0;

   reading_item_type   pending_readings[$];
   merged_reading_type expected_readings[$];
   reading_item_type   next_reading;
   reading_item_type   taken_reading;
   merged_reading_type seen_reading;
   merged_reading_type want_reading;

   int unsigned n_items = 0;
   int unsigned n_accepted = 0;
   int unsigned n_errors = 0;
   logic        req_fired = 1'b0;
   logic        rsp_fired = 1'b0;
   int unsigned req_gap = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_gap = 0;
   int unsigned rsp_calm = 0;
   int unsigned rsp_hold = 0;
   logic        pressure_done = 1'b0;

   weighted_reading_merge dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_in_status(req_in_status),
      .req_in_weight(req_in_weight),
      .req_in_rate_minute(req_in_rate_minute),
      .req_in_rate_block(req_in_rate_block),
      .req_in_total(req_in_total),
      .req_in_lat(req_in_lat),
      .req_in_lon(req_in_lon),
      .req_in_alt(req_in_alt),
      .req_in_time(req_in_time),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_status(rsp_out_status),
      .rsp_out_weight(rsp_out_weight),
      .rsp_out_rate_minute(rsp_out_rate_minute),
      .rsp_out_rate_block(rsp_out_rate_block),
      .rsp_out_total(rsp_out_total),
      .rsp_out_lat(rsp_out_lat),
      .rsp_out_lon(rsp_out_lon),
      .rsp_out_alt(rsp_out_alt),
      .rsp_out_time(rsp_out_time),
      .rsp_reportable(rsp_reportable)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic logic [RATE_W-1:0] weighted_mean(input logic [RATE_W-1:0] a,
                                                       input logic [WPORT_W-1:0] wa,
                                                       input logic [RATE_W-1:0] b,
                                                       input logic [WPORT_W-1:0] wb);
      logic [RATE_W+WPORT_W+1:0] num;
      logic [WPORT_W:0]          den;
      num = (RATE_W+WPORT_W+2)'(a) * (RATE_W+WPORT_W+2)'(wa)
          + (RATE_W+WPORT_W+2)'(b) * (RATE_W+WPORT_W+2)'(wb);
      den = (WPORT_W+1)'(wa) + (WPORT_W+1)'(wb);
      return RATE_W'(num / den);
   endfunction

   function automatic merged_reading_type merge_reading(input reading_item_type it);
      merged_reading_type res;
      logic [RATE_W-1:0]  rm;
      logic [RATE_W-1:0]  rb;
      logic [WPORT_W:0]   wsum;
      rm = it.rate_minute;
      rb = it.rate_block;
      if (it.func == FUNC_CLEAR) begin
         held_weight = '0;
         held_status = '0;
      end else if (it.status[ST_VALID] && it.weight != '0) begin
         if (held_weight == '0) begin
            held_status      = it.status;
            held_weight      = it.weight;
            held_rate_minute = rm;
            held_rate_block  = rb;
            held_total       = it.total;
            held_lat         = it.lat;
            held_lon         = it.lon;
            held_alt         = it.alt;
            held_stamp       = it.stamp;
         end else begin
            held_stamp = it.stamp;
            held_total = it.total;
            held_status[ST_PARSED] = held_status[ST_PARSED] | it.status[ST_PARSED];
            // a side without a working sensor borrows the other side's rates
            if (!held_status[ST_SENSOR] && it.status[ST_SENSOR]) begin
               held_status[ST_SENSOR] = 1'b1;
               held_rate_minute = rm;
               held_rate_block  = rb;
            end else if (held_status[ST_SENSOR] && !it.status[ST_SENSOR]) begin
               rm = held_rate_minute;
               rb = held_rate_block;
            end
            held_rate_minute = weighted_mean(held_rate_minute, held_weight, rm, it.weight);
            held_rate_block  = weighted_mean(held_rate_block, held_weight, rb, it.weight);
            if (it.status[ST_GPS]) begin
               held_status[ST_GPS] = 1'b1;
               held_lat = it.lat;
               held_lon = it.lon;
               held_alt = it.alt;
            end
            wsum = (WPORT_W+1)'(held_weight) + (WPORT_W+1)'(it.weight);
            held_weight = (wsum > (WPORT_W+1)'(WEIGHT_MAX)) ? WEIGHT_MAX : wsum[WPORT_W-1:0];
         end
      end
      res.status      = held_status;
      res.weight      = held_weight;
      res.rate_minute = held_rate_minute;
      res.rate_block  = held_rate_block;
      res.total       = held_total;
      res.lat         = held_lat;
      res.lon         = held_lon;
      res.alt         = held_alt;
      res.stamp       = held_stamp;
      res.reportable  = (held_weight != '0) && held_status[ST_SENSOR] && held_status[ST_GPS];
      return res;
   endfunction

   // mostly short gaps, some long ones, and now and then a stretch with none
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) begin
         calm = $urandom_range(80, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 96) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic note_error(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got)
         note_error($sformatf("%s expected %h, got %h", field, want, got));
   endtask

   task automatic add_reading(input logic f, input logic [STATUS_W-1:0] st,
                              input logic [WPORT_W-1:0] w, input logic [RATE_W-1:0] rm,
                              input logic [RATE_W-1:0] rb, input logic [COUNT_W-1:0] tot,
                              input logic [LAT_W-1:0] la, input logic [LON_W-1:0] lo,
                              input logic [ALT_W-1:0] al, input logic [TIME_W-1:0] ts);
      reading_item_type it;
      it.func        = f;
      it.status      = st;
      it.weight      = w;
      it.rate_minute = rm;
      it.rate_block  = rb;
      it.total       = tot;
      it.lat         = la;
      it.lon         = lo;
      it.alt         = al;
      it.stamp       = ts;
      pending_readings.push_back(it);
      n_items++;
   endtask

   // sender
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fired) begin
            // hold until the transaction is taken
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_readings.size() > 0) begin
            next_reading = pending_readings.pop_front();
            req_func           <= next_reading.func;
            req_in_status      <= next_reading.status;
            req_in_weight      <= next_reading.weight;
            req_in_rate_minute <= next_reading.rate_minute;
            req_in_rate_block  <= next_reading.rate_block;
            req_in_total       <= next_reading.total;
            req_in_lat         <= next_reading.lat;
            req_in_lon         <= next_reading.lon;
            req_in_alt         <= next_reading.alt;
            req_in_time        <= next_reading.stamp;
            req_valid          <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fired <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         taken_reading.func        = req_func;
         taken_reading.status      = req_in_status;
         taken_reading.weight      = req_in_weight;
         taken_reading.rate_minute = req_in_rate_minute;
         taken_reading.rate_block  = req_in_rate_block;
         taken_reading.total       = req_in_total;
         taken_reading.lat         = req_in_lat;
         taken_reading.lon         = req_in_lon;
         taken_reading.alt         = req_in_alt;
         taken_reading.stamp       = req_in_time;
         expected_readings.push_back(merge_reading(taken_reading));
         n_accepted++;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else if (!pressure_done && n_accepted >= PRESSURE_AT) begin
            // back up the block long enough to stall its input
            pressure_done = 1'b1;
            rsp_hold = PRESSURE_LEN;
            rsp_ready <= 1'b0;
         end else if (rsp_ready && !rsp_fired) begin
            // keep ready until a transaction goes through
         end else if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin
      rsp_fired <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            note_error("result arrived with nothing expected");
         end else begin
            want_reading = expected_readings.pop_front();
            seen_reading.status      = rsp_out_status;
            seen_reading.weight      = rsp_out_weight;
            seen_reading.rate_minute = rsp_out_rate_minute;
            seen_reading.rate_block  = rsp_out_rate_block;
            seen_reading.total       = rsp_out_total;
            seen_reading.lat         = rsp_out_lat;
            seen_reading.lon         = rsp_out_lon;
            seen_reading.alt         = rsp_out_alt;
            seen_reading.stamp       = rsp_out_time;
            seen_reading.reportable  = rsp_reportable;
            check_field("status", want_reading.status, seen_reading.status);
            check_field("weight", want_reading.weight, seen_reading.weight);
            check_field("rate_minute", want_reading.rate_minute, seen_reading.rate_minute);
            check_field("rate_block", want_reading.rate_block, seen_reading.rate_block);
            check_field("total", want_reading.total, seen_reading.total);
            check_field("lat", want_reading.lat, seen_reading.lat);
            check_field("lon", want_reading.lon, seen_reading.lon);
            check_field("alt", want_reading.alt, seen_reading.alt);
            check_field("time", want_reading.stamp, seen_reading.stamp);
            check_field("reportable", want_reading.reportable, seen_reading.reportable);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int unsigned           n_random;
      int unsigned           p;
      logic                  f;
      logic [STATUS_W-1:0]   st;
      logic [WPORT_W-1:0]    w;
      logic [RATE_W-1:0]     rm;
      logic [RATE_W-1:0]     rb;
      logic [LAT_W-1:0]      la;
      logic [LON_W-1:0]      lo;
      logic [ALT_W-1:0]      al;

      // directed: ignored items, copy-in, saturation, sensor fallback, gps, clear
      add_reading(FUNC_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      add_reading(FUNC_MERGE, SB_PARSED | SB_SENSOR | SB_GPS, 16'd5, 16'd100, 16'd7,
                  16'd1, 31'sd1, 32'sd1, 21'sd1, 64'd1);
      add_reading(FUNC_MERGE, '1, '0, 16'd100, 16'd7, 16'd1, 31'sd1, 32'sd1, 21'sd1, 64'd1);
      add_reading(FUNC_MERGE, '1, 16'd1, '1, '1, '1, 31'sd900000000,
                  -32'sd1800000000, 21'sd1000000, '1);
      add_reading(FUNC_MERGE, SB_VALID, WEIGHT_MAX, '0, '0, '0, '0, '0, '0, '0);
      add_reading(FUNC_MERGE, SB_VALID | SB_SENSOR | SB_GPS, WEIGHT_MAX, '0, '0, 16'd42,
                  -31'sd900000000, 32'sd1800000000, -21'sd100000, '0);
      add_reading(FUNC_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      add_reading(FUNC_MERGE, SB_VALID, 16'd3, 16'd900, 16'd75, 16'd10, 31'sd12345,
                  32'sd54321, 21'sd500, 64'h0123_4567_89ab_cdef);
      add_reading(FUNC_MERGE, SB_VALID | SB_SENSOR, 16'd5, 16'd300, 16'd25, 16'd11,
                  31'sd1, 32'sd2, 21'sd3, 64'd2);
      add_reading(FUNC_MERGE, SB_VALID | SB_PARSED, 16'd2, 16'd9999, 16'd999, 16'd12,
                  31'sd4, 32'sd5, 21'sd6, 64'd3);
      add_reading(FUNC_MERGE, SB_VALID | SB_GPS, 16'd7, 16'd10, 16'd1, 16'd13,
                  -31'sd123456789, 32'sd987654321, 21'sd7777, 64'd4);
      add_reading(FUNC_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      add_reading(FUNC_MERGE, SB_VALID | SB_PARSED | SB_SENSOR | SB_GPS, 16'd100, 16'd60,
                  16'd5, 16'd20, 31'sd1000, 32'sd2000, 21'sd300, 64'd5);
      add_reading(FUNC_MERGE, SB_VALID | SB_SENSOR, 16'd300, 16'd61, 16'd9, 16'd21,
                  31'sd0, 32'sd0, 21'sd0, 64'd6);
      add_reading(FUNC_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      add_reading(FUNC_MERGE, SB_VALID, 16'd10, 16'd100, 16'd8, 16'd30, 31'sd1, 32'sd1,
                  21'sd1, 64'd7);
      add_reading(FUNC_MERGE, SB_VALID, 16'd20, 16'd400, 16'd33, 16'd31, 31'sd1, 32'sd1,
                  21'sd1, 64'd8);
      // coordinates outside the legal ranges pass through unchanged
      add_reading(FUNC_MERGE, SB_VALID | SB_GPS, 16'd1, 16'd1, 16'd1, 16'd32,
                  31'h4000_0000, 32'h8000_0000, 21'h10_0000, 64'h8000_0000_0000_0000);
      add_reading(FUNC_MERGE, SB_VALID | SB_GPS, 16'd1, 16'd1, 16'd1, 16'd33,
                  31'h3fff_ffff, 32'h7fff_ffff, 21'h0f_ffff, 64'h7fff_ffff_ffff_ffff);

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         p = $urandom_range(99);
         f = FUNC_MERGE;
         st = STATUS_W'($urandom) | SB_VALID;
         w = WPORT_W'($urandom_range(200, 1));
         if ($urandom_range(99) < 4) w = WEIGHT_MAX;
         else if ($urandom_range(99) < 10) w = WPORT_W'($urandom_range(65535, 1));
         rm = RATE_W'($urandom);
         rb = RATE_W'($urandom);
         case ($urandom_range(19))
            0: rm = '0;
            1: rm = '1;
            2: rb = '0;
            3: rb = '1;
            default: ;
         endcase
         if ($urandom_range(9) == 0) begin
            la = LAT_W'($urandom);
            lo = LON_W'($urandom);
            al = ALT_W'($urandom);
         end else begin
            la = LAT_W'(int'($urandom_range(1800000000)) - 900000000);
            lo = LON_W'(longint'($urandom_range(32'd3600000000)) - 64'sd1800000000);
            al = ALT_W'(int'($urandom_range(1100000)) - 100000);
         end
         if (p < 6) begin
            f = FUNC_CLEAR;
            st = STATUS_W'($urandom);
         end else if (p < 10) begin
            st = STATUS_W'($urandom) & ~SB_VALID;
         end else if (p < 13) begin
            st = STATUS_W'($urandom);
            w = '0;
         end
         add_reading(f, st, w, rm, rb, RATE_W'($urandom), la, lo, al,
                     {$urandom, $urandom});
         n_random++;
      end

      while (n_accepted < n_items) @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
